/* rtl/prs_pkg.sv */
// shared types and constants for the polyline resampler
// operation codes and handshake structs of the iterative arithmetic unit
// no dependencies
`default_nettype none

package prs_pkg;

	// operand and result widths of the iterative unit
	localparam int unsigned OPA_W  = 68;
	localparam int unsigned OPB_W  = 35;
	localparam int unsigned REM_W  = 37;
	localparam int unsigned ROOT_W = 34;
	localparam int unsigned CNT_W  = 7;

	// steps per operation
	localparam logic [CNT_W-1:0] MUL_STEPS  = 7'd35;
	localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd68;
	localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd34;

	// reset value of the spacing register (1.0 in Q15.16)
	localparam logic [30:0] SPACING_RST = 31'd65536;

	// total length saturation value
	localparam logic [47:0] LEN_CAP = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

/* rtl/prs_iter_unit.sv */
// iterative arithmetic unit: shift-add multiply, restoring divide, restoring square root
// one step per cycle, operands taken at start, results held until the next start
// depends on prs_pkg
`default_nettype none

module prs_iter_unit
	import prs_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire unit_cmd_t          cmd,
	input  wire logic [OPA_W-1:0]   opa,
	input  wire logic [OPB_W-1:0]   opb,
	output unit_stat_t              stat,
	output logic      [OPA_W-1:0]   res,
	output logic      [REM_W-1:0]   rem,
	output logic      [ROOT_W-1:0]  root
);

	op_t              op_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OPA_W-1:0] acc_q;
	logic [OPA_W-1:0] aux_q;
	logic [OPB_W-1:0] mlt_q;
	logic [REM_W-1:0] rem_q;

	logic [OPA_W-1:0] mul_sum;
	logic [REM_W-1:0] div_rs;
	logic [REM_W-1:0] div_d;
	logic             div_ge;
	logic [REM_W-1:0] sq_rs;
	logic [REM_W-1:0] sq_trial;
	logic             sq_ge;

	// multiply: add shifted multiplicand where the multiplier bit is set
	assign mul_sum  = acc_q + (mlt_q[0] ? aux_q : '0);
	// divide: numerator shifts out the top, quotient bits in at the bottom
	assign div_rs   = {rem_q[REM_W-2:0], acc_q[OPA_W-1]};
	assign div_d    = {2'b00, mlt_q};
	assign div_ge   = div_rs >= div_d;
	// square root: two radicand bits per step
	assign sq_rs    = {rem_q[REM_W-3:0], acc_q[OPA_W-1:OPA_W-2]};
	assign sq_trial = {1'b0, aux_q[ROOT_W-1:0], 2'b01};
	assign sq_ge    = sq_rs >= sq_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (cmd.start) begin
				op_q   <= cmd.op;
				busy_q <= 1'b1;
				case (cmd.op)
					OP_MUL:  cnt_q <= MUL_STEPS;
					OP_DIV:  cnt_q <= DIV_STEPS;
					OP_SQRT: cnt_q <= SQRT_STEPS;
					default: cnt_q <= MUL_STEPS;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			mlt_q <= opb;
			case (cmd.op)
				OP_MUL: begin
					acc_q <= '0;
					aux_q <= opa;
				end
				OP_DIV: begin
					acc_q <= opa;
					aux_q <= '0;
				end
				OP_SQRT: begin
					acc_q <= opa;
					aux_q <= '0;
				end
				default: begin
					acc_q <= '0;
					aux_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					acc_q <= mul_sum;
					aux_q <= {aux_q[OPA_W-2:0], 1'b0};
					mlt_q <= {1'b0, mlt_q[OPB_W-1:1]};
				end
				OP_DIV: begin
					rem_q <= div_ge ? (div_rs - div_d) : div_rs;
					acc_q <= {acc_q[OPA_W-2:0], div_ge};
				end
				OP_SQRT: begin
					rem_q <= sq_ge ? (sq_rs - sq_trial) : sq_rs;
					aux_q <= {aux_q[OPA_W-2:0], sq_ge};
					acc_q <= {acc_q[OPA_W-3:0], 2'b00};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign res       = acc_q;
	assign rem       = rem_q;
	assign root      = aux_q[ROOT_W-1:0];

endmodule

`default_nettype wire

/* rtl/polyline_arclength_resampler_top.sv */
// polyline arc-length resampler, top level: sequencer around one iterative unit
// first vertex: sent as it is; later vertex: 3 squarings and a square root,
// then per emitted point 3 x (multiply + divide), skipped on a zero-length segment
// a capped vertex adds one divide for the residual wrap; one vertex at a time
// the shared unit sets the pace; input stall is high from acceptance until the vertex is done
// asynchronous active-low reset clears the path state and loads spacing with 1.0
`default_nettype none

module polyline_arclength_resampler_top
	import prs_pkg::*;
#(
	parameter int unsigned MAX_PER_SEGMENT = 63,
	parameter int unsigned MAX_OUTPUTS     = 16384
) (
	input  wire                clk,
	input  wire                arst_n,
	// configuration
	input  wire                cfg_we,
	input  wire logic [30:0]   cfg_data,
	// vertex channel
	input  wire                in_valid,
	output logic               in_stall,
	input  wire logic [31:0]   vx,
	input  wire logic [31:0]   vy,
	input  wire logic [31:0]   vz,
	input  wire                final_vertex,
	// point channel
	output logic               out_valid,
	input  wire                out_stall,
	output logic [31:0]        px,
	output logic [31:0]        py,
	output logic [31:0]        pz,
	output logic               run_last,
	output logic               path_end,
	output logic [47:0]        total_length,
	output logic               truncated
);

	localparam int unsigned PW = $clog2(MAX_PER_SEGMENT + 1);
	localparam int unsigned EW = $clog2(MAX_OUTPUTS);

	// sequencer states
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_FIRST = 10'b00_0000_0010,
		S_SQ    = 10'b00_0000_0100,
		S_SQRT  = 10'b00_0000_1000,
		S_LOOP  = 10'b00_0001_0000,
		S_IMUL  = 10'b00_0010_0000,
		S_IDIV  = 10'b00_0100_0000,
		S_PUT   = 10'b00_1000_0000,
		S_MOD   = 10'b01_0000_0000,
		S_END   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [30:0] spacing_q;
	logic [30:0] s_eff;
	logic [34:0] s35;

	// current vertex and its segment vector
	logic [31:0] v_q [0:2];
	logic [32:0] d_q [0:2];
	logic        fin_q;

	// path state
	logic [31:0]   prev_q [0:2];
	logic          have_prev_q;
	logic [34:0]   r_q;
	logic [47:0]   len_q;
	logic [EW-1:0] emit_q;
	logic [PW-1:0] per_q;
	logic          trunc_q;

	// working registers
	logic [65:0] sum_q;
	logic [33:0] seg_q;
	logic [33:0] e_q;
	logic [1:0]  axis_q;
	logic        wait_q;
	logic [31:0] pt_q [0:2];

	// output register
	logic        out_valid_q;
	logic [31:0] px_q;
	logic [31:0] py_q;
	logic [31:0] pz_q;
	logic        run_last_q;
	logic        path_end_q;
	logic [47:0] total_q;
	logic        trunc_out_q;

	// shared unit
	unit_cmd_t         ucmd;
	unit_stat_t        ustat;
	logic [OPA_W-1:0]  uopa;
	logic [OPB_W-1:0]  uopb;
	logic [OPA_W-1:0]  ures;
	logic [REM_W-1:0]  urem;
	logic [ROOT_W-1:0] uroot;

	// combinational helpers
	logic        accept;
	logic        slot_free;
	logic        out_load;
	logic [32:0] d_sel;
	logic [32:0] abs_d;
	logic [33:0] seg_new;
	logic [48:0] len_sum;
	logic        r_gt;
	logic        r_eq;
	logic        go_on;
	logic        cap_hit;
	logic [34:0] r_next;
	logic        more;
	logic        rnd_up;
	logic [31:0] q32;
	logic [31:0] coord;
	logic [31:0] v_sel;

	prs_iter_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ucmd),
		.opa    (uopa),
		.opb    (uopb),
		.stat   (ustat),
		.res    (ures),
		.rem    (urem),
		.root   (uroot)
	);

	// zero spacing behaves as the smallest step
	assign s_eff     = (spacing_q == '0) ? 31'd1 : spacing_q;
	assign s35       = {4'b0000, s_eff};

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	// a point enters the output register in this cycle
	assign out_load  = slot_free &&
	                   (state_q == S_FIRST || state_q == S_PUT || state_q == S_END);

	assign d_sel = d_q[axis_q];
	assign v_sel = v_q[axis_q];
	assign abs_d = d_sel[32] ? (33'd0 - d_sel) : d_sel;

	// rounded square root: round up when the remainder exceeds the root
	assign seg_new = uroot + 34'(urem > {3'b000, uroot});
	assign len_sum = {1'b0, len_q} + {15'd0, seg_new};

	// emission test on the running residual
	assign r_gt    = r_q > s35;
	assign r_eq    = r_q == s35;
	assign go_on   = r_gt || (fin_q && r_eq);
	assign cap_hit = (per_q >= PW'(MAX_PER_SEGMENT)) || (emit_q >= EW'(MAX_OUTPUTS - 1));

	// whether another point of this vertex follows the one being sent
	assign r_next = r_q - s35;
	assign more   = ((r_next > s35) || (fin_q && (r_next == s35)))
	                && (({1'b0, per_q} + (PW+1)'(1)) < (PW+1)'(MAX_PER_SEGMENT))
	                && (({1'b0, emit_q} + (EW+1)'(1)) < (EW+1)'(MAX_OUTPUTS - 1));

	// interpolation: round half up in magnitude, then apply the sign of the segment axis
	assign rnd_up = {urem[34:0], 1'b0} >= {2'b00, seg_q};
	assign q32    = ures[31:0] + 32'(rnd_up);
	assign coord  = d_sel[32] ? (v_sel + q32) : (v_sel - q32);

	// unit command and operands
	always_comb begin
		ucmd.start = 1'b0;
		ucmd.op    = OP_MUL;
		uopa       = '0;
		uopb       = '0;
		case (state_q)
			S_SQ: begin
				ucmd.start = !wait_q;
				ucmd.op    = OP_MUL;
				uopa       = {35'd0, abs_d};
				uopb       = {2'b00, abs_d};
			end
			S_SQRT: begin
				ucmd.start = !wait_q;
				ucmd.op    = OP_SQRT;
				uopa       = {2'b00, sum_q};
			end
			S_IMUL: begin
				ucmd.start = !wait_q && (seg_q != '0);
				ucmd.op    = OP_MUL;
				uopa       = {35'd0, abs_d};
				uopb       = {1'b0, e_q};
			end
			S_IDIV: begin
				ucmd.start = !wait_q;
				ucmd.op    = OP_DIV;
				uopa       = ures;
				uopb       = {1'b0, seg_q};
			end
			S_MOD: begin
				// wrap the residual into (0, spacing] after a cap
				ucmd.start = !wait_q;
				ucmd.op    = OP_DIV;
				uopa       = {33'd0, r_q - 35'd1};
				uopb       = s35;
			end
			default: begin
				ucmd.start = 1'b0;
			end
		endcase
	end

	// sequencer and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			spacing_q   <= SPACING_RST;
			have_prev_q <= 1'b0;
			prev_q[0]   <= '0;
			prev_q[1]   <= '0;
			prev_q[2]   <= '0;
			r_q         <= '0;
			len_q       <= '0;
			emit_q      <= '0;
			per_q       <= '0;
			trunc_q     <= 1'b0;
			wait_q      <= 1'b0;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				spacing_q <= cfg_data;
			end
			if (ucmd.start) begin
				wait_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (slot_free) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_q[0] <= vx;
						prev_q[1] <= vy;
						prev_q[2] <= vz;
						axis_q    <= '0;
						state_q   <= have_prev_q ? S_SQ : S_FIRST;
					end
				end
				S_FIRST: begin
					if (slot_free) begin
						emit_q      <= EW'(1);
						have_prev_q <= 1'b1;
						state_q     <= fin_q ? S_END : S_IDLE;
					end
				end
				S_SQ: begin
					if (ustat.done) begin
						wait_q <= 1'b0;
						if (axis_q == 2'd2) begin
							state_q <= S_SQRT;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end
				end
				S_SQRT: begin
					if (ustat.done) begin
						wait_q  <= 1'b0;
						r_q     <= r_q + {1'b0, seg_new};
						len_q   <= len_sum[48] ? LEN_CAP : len_sum[47:0];
						per_q   <= '0;
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					if (!go_on) begin
						state_q <= fin_q ? S_END : S_IDLE;
					end else if (cap_hit) begin
						trunc_q <= 1'b1;
						if (r_gt) begin
							state_q <= S_MOD;
						end else begin
							state_q <= fin_q ? S_END : S_IDLE;
						end
					end else begin
						axis_q  <= '0;
						state_q <= S_IMUL;
					end
				end
				S_IMUL: begin
					if (seg_q == '0) begin
						// zero-length segment: the point is the vertex itself
						if (axis_q == 2'd2) begin
							state_q <= S_PUT;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else if (ustat.done) begin
						wait_q  <= 1'b0;
						state_q <= S_IDIV;
					end
				end
				S_IDIV: begin
					if (ustat.done) begin
						wait_q <= 1'b0;
						if (axis_q == 2'd2) begin
							state_q <= S_PUT;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_IMUL;
						end
					end
				end
				S_PUT: begin
					if (slot_free) begin
						per_q       <= per_q + PW'(1);
						emit_q      <= emit_q + EW'(1);
						r_q         <= r_next;
						state_q     <= S_LOOP;
					end
				end
				S_MOD: begin
					if (ustat.done) begin
						wait_q  <= 1'b0;
						r_q     <= urem[34:0] + 35'd1;
						state_q <= fin_q ? S_END : S_IDLE;
					end
				end
				S_END: begin
					if (slot_free) begin
						// close the path: clear the path state and return to idle
						have_prev_q <= 1'b0;
						prev_q[0]   <= '0;
						prev_q[1]   <= '0;
						prev_q[2]   <= '0;
						r_q         <= '0;
						len_q       <= '0;
						emit_q      <= '0;
						per_q       <= '0;
						trunc_q     <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q[0] <= vx;
			v_q[1] <= vy;
			v_q[2] <= vz;
			d_q[0] <= {vx[31], vx} - {prev_q[0][31], prev_q[0]};
			d_q[1] <= {vy[31], vy} - {prev_q[1][31], prev_q[1]};
			d_q[2] <= {vz[31], vz} - {prev_q[2][31], prev_q[2]};
			fin_q  <= final_vertex;
			sum_q  <= '0;
		end
		if (state_q == S_SQ && ustat.done) begin
			sum_q <= sum_q + ures[65:0];
		end
		if (state_q == S_SQRT && ustat.done) begin
			seg_q <= seg_new;
		end
		if (state_q == S_LOOP) begin
			e_q <= r_next[33:0];
		end
		if (state_q == S_IMUL && seg_q == '0) begin
			pt_q[axis_q] <= v_sel;
		end
		if (state_q == S_IDIV && ustat.done) begin
			pt_q[axis_q] <= coord;
		end

		// output register loads
		if (state_q == S_FIRST && slot_free) begin
			px_q        <= v_q[0];
			py_q        <= v_q[1];
			pz_q        <= v_q[2];
			run_last_q  <= !fin_q;
			path_end_q  <= 1'b0;
			total_q     <= '0;
			trunc_out_q <= trunc_q;
		end else if (state_q == S_PUT && slot_free) begin
			px_q        <= pt_q[0];
			py_q        <= pt_q[1];
			pz_q        <= pt_q[2];
			run_last_q  <= !fin_q && !more;
			path_end_q  <= 1'b0;
			total_q     <= '0;
			trunc_out_q <= trunc_q;
		end else if (state_q == S_END && slot_free) begin
			px_q        <= v_q[0];
			py_q        <= v_q[1];
			pz_q        <= v_q[2];
			run_last_q  <= 1'b1;
			path_end_q  <= 1'b1;
			total_q     <= len_q;
			trunc_out_q <= trunc_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign px           = px_q;
	assign py           = py_q;
	assign pz           = pz_q;
	assign run_last     = run_last_q;
	assign path_end     = path_end_q;
	assign total_length = total_q;
	assign truncated    = trunc_out_q;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench for polyline_arclength_resampler_top
// holds its own predictor of the resampler; depends on rtl/prs_pkg.sv and the top level
`default_nettype none

module testbench;
	import prs_pkg::*;

	localparam int SEG_CAP    = 63;
	localparam int PATH_CAP   = 16384;
	localparam int WDOG_LIMIT = 40000;
	localparam int HOLD_LEN   = 3000;
	localparam int SETTLE     = 600;
	localparam int NO_CFG     = -1;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic        run_last;
		logic        path_end;
		logic [47:0] total_length;
		logic        truncated;
	} point_t;

	// one row of the directed part; cfg other than NO_CFG is written before the vertex
	typedef struct {
		longint      cfg;
		logic [31:0] x, y, z;
		bit          fin;
		bit          chk;
		logic [31:0] ex, ey, ez;
	} stim_row_t;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [30:0] cfg_data;
	logic        in_valid, in_stall;
	logic [31:0] vx, vy, vz;
	logic        final_vertex;
	logic        out_valid, out_stall;
	logic [31:0] px, py, pz;
	logic        run_last, path_end, truncated;
	logic [47:0] total_length;

	polyline_arclength_resampler_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.vx(vx), .vy(vy), .vz(vz), .final_vertex(final_vertex),
		.out_valid(out_valid), .out_stall(out_stall),
		.px(px), .py(py), .pz(pz), .run_last(run_last), .path_end(path_end),
		.total_length(total_length), .truncated(truncated)
	);

	// predictor state, a copy of the block's path state and spacing
	logic [30:0] spacing_reg;
	longint      last_x, last_y, last_z;
	bit          have_last;
	logic [63:0] residual;
	logic [47:0] length_sum;
	int          emitted;
	bit          trunc_seen;
	// number of points predicted for the latest vertex
	int          batch_len;

	point_t points_due[$];
	bit     failed;
	int     snd_idle_pct, rcv_idle_pct;
	bit     hold_ask;
	int     hold_cnt;
	int     quiet_cycles;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_path();
		last_x = 0; last_y = 0; last_z = 0;
		have_last = 0;
		residual = 0;
		length_sum = 0;
		emitted = 0;
		trunc_seen = 0;
	endfunction

	// rounded integer square root of the squared segment length
	function automatic logic [63:0] seg_length(logic [67:0] sq);
		logic [67:0] r, c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (68'd1 << b);
			if (c * c <= sq)
				r = c;
		end
		if (sq - r * r > r)
			r = r + 1;
		return r[63:0];
	endfunction

	// point lying e back from v along a segment of vector d and length seg
	function automatic logic [31:0] along(longint v, longint d, logic [63:0] e,
			logic [63:0] seg);
		logic [127:0] num, q, rem;
		logic [63:0]  mag;
		longint       res;
		if (seg == 0)
			return v[31:0];
		mag = (d < 0) ? -d : d;
		num = 128'(mag) * 128'(e);
		q = num / 128'(seg);
		rem = num % 128'(seg);
		if (2 * rem >= 128'(seg))
			q = q + 1;
		res = (d < 0) ? v + longint'(q) : v - longint'(q);
		return res[31:0];
	endfunction

	function automatic point_t mk_point(logic [31:0] x, y, z, logic endp, logic [47:0] tot);
		point_t p;
		p.px = x; p.py = y; p.pz = z;
		p.run_last = 0;
		p.path_end = endp;
		p.total_length = tot;
		p.truncated = trunc_seen;
		return p;
	endfunction

	// expected points for one accepted vertex, appended to points_due
	function automatic void resample_vertex(logic [31:0] x, y, z, bit fin);
		point_t      batch[$];
		longint      sx, sy, sz, dx, dy, dz;
		logic [63:0] ax, ay, az, seg, r, s, e;
		int          per;
		sx = longint'($signed(x));
		sy = longint'($signed(y));
		sz = longint'($signed(z));
		s = (spacing_reg == 0) ? 64'd1 : 64'(spacing_reg);
		if (!have_last) begin
			batch.push_back(mk_point(x, y, z, 0, 0));
			emitted = 1;
			have_last = 1;
		end else begin
			dx = sx - last_x; dy = sy - last_y; dz = sz - last_z;
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			az = (dz < 0) ? -dz : dz;
			seg = seg_length(68'(ax) * 68'(ax) + 68'(ay) * 68'(ay) + 68'(az) * 68'(az));
			r = residual + seg;
			per = 0;
			length_sum = (LEN_CAP - length_sum < seg) ? LEN_CAP : length_sum + seg[47:0];
			while (r > s || (fin && r == s)) begin
				if (per >= SEG_CAP || emitted >= PATH_CAP - 1) begin
					trunc_seen = 1;
					if (r > s)
						r = ((r - 1) % s) + 1;
					break;
				end
				e = r - s;
				batch.push_back(mk_point(along(sx, dx, e, seg), along(sy, dy, e, seg),
					along(sz, dz, e, seg), 0, 0));
				per++;
				emitted++;
				r = r - s;
			end
			residual = r;
		end
		last_x = sx; last_y = sy; last_z = sz;
		if (fin) begin
			batch.push_back(mk_point(x, y, z, 1, length_sum));
			clear_path();
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].run_last = 1;
		batch_len = batch.size();
		foreach (batch[i])
			points_due.push_back(batch[i]);
	endfunction

	// present one vertex and hold it until the transfer
	task automatic send_vertex(logic [31:0] x, y, z, bit fin);
		while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		vx <= x; vy <= y; vz <= z;
		final_vertex <= fin;
		do @(posedge clk); while (in_stall);
		resample_vertex(x, y, z, fin);
	endtask

	// wait for every expected point, then for any vertex still in flight with no result
	task automatic drain();
		in_valid <= 0;
		while (points_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_spacing(logic [30:0] v);
		drain();
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		spacing_reg = v;
	endtask

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_ask) begin
			hold_ask = 0;
			hold_cnt = HOLD_LEN;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1;
		end else
			out_stall <= (rcv_idle_pct > 0 && $urandom_range(99) < rcv_idle_pct);
	end

	// check each point transfer against the oldest expected point
	always @(posedge clk) begin
		point_t exp_pt, got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{px, py, pz, run_last, path_end, total_length, truncated};
			if (points_due.size() == 0) begin
				$display("%0t: unexpected point %h", $time, got);
				failed = 1;
			end else begin
				exp_pt = points_due.pop_front();
				if (got !== exp_pt) begin
					$display("%0t: point mismatch expected px %h py %h pz %h last %b end %b tot %h trunc %b",
						$time, exp_pt.px, exp_pt.py, exp_pt.pz, exp_pt.run_last,
						exp_pt.path_end, exp_pt.total_length, exp_pt.truncated);
					$display("%0t:                actual px %h py %h pz %h last %b end %b tot %h trunc %b",
						$time, got.px, got.py, got.pz, got.run_last, got.path_end,
						got.total_length, got.truncated);
					failed = 1;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("FAIL polyline_arclength_resampler_top");
			$finish;
		end
	end

	// random polyline: small steps on the spacing scale, now and then a long jump
	task automatic random_polyline(inout int left);
		int          nv, lim;
		logic [31:0] x, y, z;
		nv = $urandom_range(1, 6);
		lim = (spacing_reg > (1 << 26)) ? (1 << 27) : 2 * int'(spacing_reg) + 2;
		x = $urandom; y = $urandom; z = $urandom;
		for (int i = 0; i < nv && left > 0; i++) begin
			if (i > 0) begin
				if ($urandom_range(99) < 3) begin
					x = $urandom; y = $urandom; z = $urandom;
				end else if ($urandom_range(99) >= 5) begin
					x = x + 32'($urandom_range(0, 2 * lim) - lim);
					y = y + 32'($urandom_range(0, 2 * lim) - lim);
					z = z + 32'($urandom_range(0, 2 * lim) - lim);
				end
			end
			send_vertex(x, y, z, i == nv - 1 || left == 1);
			left--;
		end
	endtask

	stim_row_t stim_rows[] = '{
		// single vertex polylines, extremes of the coordinate range
		'{NO_CFG, 32'h0, 32'h0, 32'h0, 1, 1, 32'h0, 32'h0, 32'h0},
		'{NO_CFG, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1, 1,
			32'h7fffffff, 32'h80000000, 32'hffffffff},
		// three units along x, then a zero length final segment hitting the spacing exactly
		'{NO_CFG, 32'h0, 32'h0, 32'h0, 0, 1, 32'h0, 32'h0, 32'h0},
		'{NO_CFG, 32'h30000, 32'h0, 32'h0, 0, 1, 32'h10000, 32'h0, 32'h0},
		'{NO_CFG, 32'h30000, 32'h0, 32'h0, 1, 1, 32'h30000, 32'h0, 32'h0},
		// negative direction and a 3-4-5 diagonal
		'{NO_CFG, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
		'{NO_CFG, 32'h0, 32'hfffd8000, 32'h0, 1, 0, 0, 0, 0},
		'{NO_CFG, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
		'{NO_CFG, 32'h30000, 32'h40000, 32'h0, 1, 0, 0, 0, 0},
		// corner to corner of the coordinate cube: per-vertex cap
		'{NO_CFG, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0},
		'{NO_CFG, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0},
		'{NO_CFG, 32'h7fff0000, 32'h7fffffff, 32'h7fffffff, 1, 0, 0, 0, 0},
		// smallest spacing: the cap again on a short segment
		'{1, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
		'{NO_CFG, 32'h64, 32'hffffffce, 32'h7, 1, 0, 0, 0, 0},
		// largest spacing: a segment equal to it emits only on the final vertex
		'{32'h7fffffff, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
		'{NO_CFG, 32'h7fffffff, 32'h0, 32'h0, 0, 0, 0, 0, 0},
		'{NO_CFG, 32'h7fffffff, 32'h0, 32'h0, 1, 1, 32'h7fffffff, 32'h0, 32'h0},
		// zero spacing behaves as spacing one
		'{0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0, 0},
		'{NO_CFG, 32'h3, 32'h0, 32'h0, 1, 0, 0, 0, 0}
	};

	initial begin
		int left, n0;
		arst_n = 0;
		cfg_we = 0; cfg_data = 0;
		in_valid = 0; vx = 0; vy = 0; vz = 0; final_vertex = 0;
		out_stall = 0;
		failed = 0;
		hold_ask = 0; hold_cnt = 0; quiet_cycles = 0;
		snd_idle_pct = 0; rcv_idle_pct = 0;
		batch_len = 0;
		spacing_reg = SPACING_RST;
		clear_path();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows; typed points are checked against the predictor's first point
		foreach (stim_rows[i]) begin
			if (stim_rows[i].cfg != NO_CFG)
				write_spacing(stim_rows[i].cfg[30:0]);
			send_vertex(stim_rows[i].x, stim_rows[i].y, stim_rows[i].z, stim_rows[i].fin);
			// the new points sit at the tail of the queue
			n0 = points_due.size() - batch_len;
			if (stim_rows[i].chk && (batch_len == 0 ||
					points_due[n0].px !== stim_rows[i].ex ||
					points_due[n0].py !== stim_rows[i].ey ||
					points_due[n0].pz !== stim_rows[i].ez)) begin
				$display("%0t: row %0d expected point %h %h %h not predicted", $time, i,
					stim_rows[i].ex, stim_rows[i].ey, stim_rows[i].ez);
				failed = 1;
			end
		end

		// sender seldom idle, receiver mostly stalled, with a long hold-off
		write_spacing(SPACING_RST);
		snd_idle_pct = 6; rcv_idle_pct = 76;
		left = 100;
		while (left > 0) begin
			if (left < 60 && left > 50 && hold_cnt == 0)
				hold_ask = 1;
			random_polyline(left);
		end

		// roles swapped, random spacing
		write_spacing(31'($urandom_range(1000, 1 << 20)));
		snd_idle_pct = 76; rcv_idle_pct = 6;
		left = 100;
		while (left > 0)
			random_polyline(left);

		// back to back
		write_spacing(31'd300000);
		snd_idle_pct = 0; rcv_idle_pct = 0;
		left = 100;
		while (left > 0)
			random_polyline(left);

		drain();
		if (!failed)
			$display("PASS polyline_arclength_resampler_top");
		else
			$display("FAIL polyline_arclength_resampler_top");
		$finish;
	end

endmodule

`default_nettype wire
